FILE: src/ibmf_pkg.sv
// Shared types and constants for the index band midpoint finder.
package ibmf_pkg;

	localparam int WINDOW_DEF    = 10;
	localparam int REV_STEPS_DEF = 2048;

	localparam logic [9:0] LOW_THRESHOLD_RST  = 10'd275;
	localparam logic [9:0] RISE_THRESHOLD_RST = 10'd400;
	localparam logic [9:0] FALL_THRESHOLD_RST = 10'd350;
	localparam logic [7:0] LAG_STEPS_RST      = 8'd10;

	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		REG_LOW  = 2'd0,
		REG_RISE = 2'd1,
		REG_FALL = 2'd2,
		REG_LAG  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_ARM  = 2'd0,
		PH_RISE = 2'd1,
		PH_FALL = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	typedef struct packed {
		logic [9:0] low_threshold;
		logic [9:0] rise_threshold;
		logic [9:0] fall_threshold;
		logic [7:0] lag_steps;
	} cfg_t;

	// Tracker output word: phase and average after the update, band edges so far.
	typedef struct packed {
		phase_t             phase;
		logic [9:0]         average;
		logic signed [15:0] band_start;
		logic signed [15:0] band_end;
	} track_t;

	typedef struct packed {
		phase_t             phase;
		logic [9:0]         average;
		logic               done_res;
		logic signed [15:0] midpoint;
	} result_t;

endpackage

FILE: src/index_band_midpoint_finder_top.sv
// Top level: configuration registers, input and output registers, pipeline control.
// Each word is either a start command or a sensor sample with its motor position, and
// yields exactly one result word. One word is taken every cycle while the pipeline is not
// stalled; a result word is presented once its input word has passed the input register,
// the tracker, the midpoint stage and the output register. The running sum, the sample
// window and the search phase update in the single tracker stage, so each word sees the
// state left by the one before it. Back pressure on the result side stalls the whole
// pipeline; the input register still takes one word while the pipeline is held.
module index_band_midpoint_finder_top #(
	parameter int WINDOW    = ibmf_pkg::WINDOW_DEF,
	parameter int REV_STEPS = ibmf_pkg::REV_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [9:0]         sample,
	input  logic signed [15:0] position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         phase,
	output logic [9:0]         average,
	output logic               done_res,
	output logic signed [15:0] midpoint,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import ibmf_pkg::*;

	cfg_t               cfg_q;
	reg_idx_t           reg_idx;
	logic               cfg_wr;

	logic               en;
	logic               v_s1;
	logic               v_s2;
	logic               v_s3;
	logic               out_valid_q;
	logic               cmd_s1;
	logic [9:0]         sample_s1;
	logic signed [15:0] position_s1;
	track_t             trk_s2;
	result_t            res;
	result_t            out_q;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_threshold  <= LOW_THRESHOLD_RST;
			cfg_q.rise_threshold <= RISE_THRESHOLD_RST;
			cfg_q.fall_threshold <= FALL_THRESHOLD_RST;
			cfg_q.lag_steps      <= LAG_STEPS_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_LOW:  cfg_q.low_threshold  <= pwdata[9:0];
				REG_RISE: cfg_q.rise_threshold <= pwdata[9:0];
				REG_FALL: cfg_q.fall_threshold <= pwdata[9:0];
				REG_LAG:  cfg_q.lag_steps      <= pwdata[7:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LOW:  prdata = 32'(cfg_q.low_threshold);
			REG_RISE: prdata = 32'(cfg_q.rise_threshold);
			REG_FALL: prdata = 32'(cfg_q.fall_threshold);
			REG_LAG:  prdata = 32'(cfg_q.lag_steps);
			default:  prdata = '0;
		endcase
	end

	// Advance the pipeline whenever the output register is free or being drained.
	assign en       = !out_valid_q || !out_stall;
	assign in_stall = v_s1 && !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall)
				v_s1 <= in_valid;
			if (en) begin
				v_s2        <= v_s1;
				v_s3        <= v_s2;
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1      <= cmd;
			sample_s1   <= sample;
			position_s1 <= position;
		end
		if (en && v_s3)
			out_q <= res;
	end

	ibmf_track #(
		.WINDOW (WINDOW)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (en && v_s1),
		.cmd      (cmd_s1),
		.sample   (sample_s1),
		.position (position_s1),
		.cfg      (cfg_q),
		.trk_s2   (trk_s2)
	);

	ibmf_center #(
		.REV_STEPS (REV_STEPS)
	) u_center (
		.clk    (clk),
		.en     (en),
		.trk_s2 (trk_s2),
		.res    (res)
	);

	assign out_valid = out_valid_q;
	assign phase     = out_q.phase;
	assign average   = out_q.average;
	assign done_res  = out_q.done_res;
	assign midpoint  = out_q.midpoint;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && out_valid_q)
		else $error("input stalled with nothing held");

	a_mid_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> midpoint == 16'sd0)
		else $error("midpoint shown before band end");

endmodule

FILE: src/ibmf_track.sv
// Moving-average window and band search sequencer.
module ibmf_track #(
	parameter int WINDOW = ibmf_pkg::WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic                  cmd,
	input  logic [9:0]            sample,
	input  logic signed [15:0]    position,
	input  ibmf_pkg::cfg_t        cfg,
	output ibmf_pkg::track_t      trk_s2
);
	import ibmf_pkg::*;

	localparam int SUM_W     = $clog2(WINDOW * 1023 + 1);
	localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW);
	localparam int PROD_W    = 2 * SUM_W + 1;
	localparam logic [SUM_W:0] AVG_RECIP =
		(SUM_W + 1)'(((64'd1 << AVG_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
	localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'((WINDOW - 1) * 1023);

	logic [9:0]             hist_q [WINDOW-1];
	logic [SUM_W-1:0]       sum_q;
	phase_t                 phase_q;
	phase_t                 phase_d;
	logic signed [15:0]     start_q;
	logic signed [15:0]     start_d;
	logic signed [15:0]     end_q;
	logic signed [15:0]     end_d;
	logic [SUM_W-1:0]       total;
	logic [PROD_W-1:0]      avg_prod;
	logic [9:0]             avg;
	logic signed [15:0]     lagged;

	assign total    = sum_q + SUM_W'(sample);
	assign avg_prod = PROD_W'(total) * PROD_W'(AVG_RECIP);
	assign avg      = avg_prod[AVG_SHIFT +: 10];
	assign lagged   = position - $signed({8'd0, cfg.lag_steps});

	always_comb begin
		phase_d = phase_q;
		start_d = start_q;
		end_d   = end_q;
		if (cmd == CMD_START) begin
			phase_d = PH_ARM;
			start_d = '0;
			end_d   = '0;
		end else begin
			unique case (phase_q)
				PH_ARM: begin
					if (sample < cfg.low_threshold)
						phase_d = PH_RISE;
				end
				PH_RISE: begin
					if (avg > cfg.rise_threshold) begin
						start_d = lagged;
						phase_d = PH_FALL;
					end
				end
				PH_FALL: begin
					if (avg < cfg.fall_threshold) begin
						end_d   = lagged;
						phase_d = PH_DONE;
					end
				end
				PH_DONE: begin
					phase_d = PH_DONE;
				end
				default: phase_d = PH_ARM;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ARM;
			start_q <= '0;
			end_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			start_q <= start_d;
			end_q   <= end_d;
		end
	end

	// Window state: oldest sample sits at index 0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			for (int i = 0; i < WINDOW - 1; i++)
				hist_q[i] <= '0;
		end else if (advance) begin
			if (cmd == CMD_START) begin
				sum_q <= '0;
				for (int i = 0; i < WINDOW - 1; i++)
					hist_q[i] <= '0;
			end else begin
				sum_q <= total - SUM_W'(hist_q[0]);
				for (int i = 0; i < WINDOW - 2; i++)
					hist_q[i] <= hist_q[i+1];
				hist_q[WINDOW-2] <= sample;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			trk_s2.phase      <= phase_d;
			trk_s2.average    <= (cmd == CMD_START) ? 10'd0 : avg;
			trk_s2.band_start <= start_d;
			trk_s2.band_end   <= end_d;
		end
	end

	a_sum_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_MAX)
		else $error("running sum exceeds window capacity");

	a_arm_order: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ARM |=> phase_q == PH_ARM || phase_q == PH_RISE)
		else $error("search left arm phase out of order");

	a_fall_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd == CMD_START |=> phase_q == PH_ARM && sum_q == '0)
		else $error("start did not clear the search");

endmodule

FILE: src/ibmf_center.sv
// Band midpoint arithmetic with wrap modulo one revolution.
module ibmf_center #(
	parameter int REV_STEPS = ibmf_pkg::REV_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  ibmf_pkg::track_t     trk_s2,
	output ibmf_pkg::result_t    res
);
	import ibmf_pkg::*;

	localparam int REV_W     = $clog2(REV_STEPS);
	localparam int Q_W       = 17 - REV_W;
	localparam int REV_SHIFT = 16 + REV_W;
	localparam logic [16:0] REV_RECIP =
		17'(((64'd1 << REV_SHIFT) + 64'(REV_STEPS) - 64'd1) / 64'(REV_STEPS));

	logic signed [16:0] sum_se;
	logic signed [16:0] plain_adj;
	logic signed [17:0] wrap_full;
	logic signed [17:0] wrap_adj;
	logic signed [16:0] wrap_half;
	logic [15:0]        mag;
	logic [32:0]        q_prod;
	logic               wrap;

	phase_t             phase_s3;
	logic [9:0]         avg_s3;
	logic signed [15:0] plain_s3;
	logic [15:0]        mag_s3;
	logic               hneg_s3;
	logic               wrap_s3;
	logic [Q_W-1:0]     q_s3;

	logic [15:0]        rem;
	logic signed [15:0] wrapped;
	logic signed [15:0] mid;

	// Halve toward zero: add one to a negative value before the shift.
	assign sum_se    = 17'(trk_s2.band_start) + 17'(trk_s2.band_end);
	assign wrap      = trk_s2.band_end < trk_s2.band_start;
	assign plain_adj = sum_se + 17'(sum_se[16]);
	assign wrap_full = 18'(sum_se) + 18'(REV_STEPS);
	assign wrap_adj  = wrap_full + 18'(wrap_full[17]);
	assign wrap_half = wrap_adj[17:1];
	assign mag       = wrap_half[16] ? 16'(-wrap_half) : wrap_half[15:0];
	assign q_prod    = 33'(mag) * 33'(REV_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s3 <= trk_s2.phase;
			avg_s3   <= trk_s2.average;
			plain_s3 <= plain_adj[16:1];
			mag_s3   <= mag;
			hneg_s3  <= wrap_half[16];
			wrap_s3  <= wrap;
			q_s3     <= q_prod[REV_SHIFT +: Q_W];
		end
	end

	// Remainder keeps the sign of the halved sum.
	assign rem     = mag_s3 - 16'(32'(q_s3) * 32'(REV_STEPS));
	assign wrapped = hneg_s3 ? -$signed(rem) : $signed(rem);
	assign mid     = wrap_s3 ? wrapped : plain_s3;

	always_comb begin
		res.phase    = phase_s3;
		res.average  = avg_s3;
		res.done_res = (phase_s3 == PH_DONE);
		res.midpoint = (phase_s3 == PH_DONE) ? mid : 16'sd0;
	end

endmodule

FILE: tb/sv/ibmf_result_monitor.sv
`timescale 1ns / 100ps
// Watches the band finder's channels and register port, predicts every result word and compares.
module ibmf_result_monitor #(
	parameter int WINDOW    = ibmf_pkg::WINDOW_DEF,
	parameter int REV_STEPS = ibmf_pkg::REV_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               cmd,
	input  logic [9:0]         sample,
	input  logic signed [15:0] position,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         phase,
	input  logic [9:0]         average,
	input  logic               done_res,
	input  logic signed [15:0] midpoint,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 pending,
	output int                 words_checked,
	output int                 bands_found
);

	import ibmf_pkg::*;

	cfg_t               thresholds;
	logic [9:0]         win_hist [WINDOW-1];
	logic [13:0]        win_sum;
	phase_t             search_ph;
	logic signed [15:0] band_start;
	logic signed [15:0] band_center;
	result_t            expected_words [$];

	initial begin
		fail_count    = 0;
		pending       = 0;
		words_checked = 0;
		bands_found   = 0;
	end

	function automatic void clear_search();
		int i;
		for (i = 0; i < WINDOW - 1; i++)
			win_hist[i] = '0;
		win_sum     = '0;
		search_ph   = PH_ARM;
		band_start  = '0;
		band_center = '0;
	endfunction

	function automatic result_t advance_band_search(input logic c, input logic [9:0] s,
			input logic signed [15:0] p);
		result_t            r;
		logic [13:0]        total;
		logic signed [15:0] lagged;
		int                 i;
		int                 b;
		int                 e;
		int                 m;
		r = '0;
		if (c == CMD_START) begin
			clear_search();
		end else begin
			total     = win_sum + s;
			r.average = 10'(total / WINDOW);
			win_sum   = total - win_hist[0];
			for (i = 0; i < WINDOW - 2; i++)
				win_hist[i] = win_hist[i+1];
			win_hist[WINDOW-2] = s;
			lagged = p - 16'(thresholds.lag_steps);
			case (search_ph)
				PH_ARM: begin
					if (s < thresholds.low_threshold)
						search_ph = PH_RISE;
				end
				PH_RISE: begin
					if (r.average > thresholds.rise_threshold) begin
						band_start = lagged;
						search_ph  = PH_FALL;
					end
				end
				PH_FALL: begin
					if (r.average < thresholds.fall_threshold) begin
						b = band_start;
						e = lagged;
						// end before start: the band straddles the index, wrap one revolution
						if (e - b < 0)
							m = ((b + e + REV_STEPS) / 2) % REV_STEPS;
						else
							m = (b + e) / 2;
						band_center = 16'(m);
						search_ph   = PH_DONE;
						bands_found++;
					end
				end
				default: ;
			endcase
		end
		r.phase    = search_ph;
		r.done_res = (search_ph == PH_DONE);
		r.midpoint = band_center;
		return r;
	endfunction

	task automatic report_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			thresholds = '{LOW_THRESHOLD_RST, RISE_THRESHOLD_RST, FALL_THRESHOLD_RST,
				LAG_STEPS_RST};
			clear_search();
			expected_words.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_LOW:  thresholds.low_threshold  = pwdata[9:0];
					REG_RISE: thresholds.rise_threshold = pwdata[9:0];
					REG_FALL: thresholds.fall_threshold = pwdata[9:0];
					REG_LAG:  thresholds.lag_steps      = pwdata[7:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$display({"%0t: unexpected result word, expected none, ",
						"got phase %0d average %0d midpoint %0d"},
						$time, phase, average, midpoint);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					report_field("phase", want.phase, phase);
					report_field("average", want.average, average);
					report_field("done_res", want.done_res, done_res);
					report_field("midpoint", want.midpoint, midpoint);
					words_checked++;
				end
			end
			if (in_valid && !in_stall)
				expected_words.push_back(advance_band_search(cmd, sample, position));
		end
		pending = expected_words.size();
	end

endmodule

FILE: tb/sv/index_band_midpoint_finder_top_tb.sv
`timescale 1ns / 100ps
// Stimulus, flow control and verdict for the index band midpoint finder.
module index_band_midpoint_finder_top_tb;

	import ibmf_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int TIMEOUT_CYCLES = 200000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int BACKLOG_CYCLES = 300;
	localparam int NUM_CHUNKS     = 6;
	localparam int CHUNK_WORDS    = 280;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               cmd;
	logic [9:0]         sample;
	logic signed [15:0] position;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         phase;
	logic [9:0]         average;
	logic               done_res;
	logic signed [15:0] midpoint;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int   fail_count;
	int   pending;
	int   words_checked;
	int   bands_found;
	int   sent_words  = 0;
	int   tx_idle_pct = 38;
	int   rx_idle_pct = 59;
	int   backlog_req = 0;
	cfg_t cur_cfg;

	always #(HALF_PERIOD) clk = ~clk;

	index_band_midpoint_finder_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .sample(sample), .position(position),
		.out_valid(out_valid), .out_stall(out_stall),
		.phase(phase), .average(average), .done_res(done_res), .midpoint(midpoint),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	ibmf_result_monitor u_monitor (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .sample(sample), .position(position),
		.out_valid(out_valid), .out_stall(out_stall),
		.phase(phase), .average(average), .done_res(done_res), .midpoint(midpoint),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .pending(pending),
		.words_checked(words_checked), .bands_found(bands_found)
	);

	initial begin
		#(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
		$display("Simulation FAILED");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		int backlog_seen;
		hold_left    = 0;
		backlog_seen = 0;
		out_stall    = 1'b0;
		forever begin
			@(negedge clk);
			if (backlog_seen != backlog_req) begin
				backlog_seen = backlog_req;
				hold_left    = BACKLOG_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else
				out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	task automatic send_word(input logic c, input logic [9:0] s, input logic signed [15:0] p);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		sample   <= s;
		position <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_words++;
		@(negedge clk);
	endtask

	// Random upper bits check that the register masks its width
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value, input int width);
		logic [31:0] mask;
		mask = (32'd1 << width) - 1;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= (value & mask) | ($urandom() & ~mask);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic drain_results();
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_setting(input int which);
		cfg_t next;
		case (which)
			1: next = '{10'h3FF, 10'd0, 10'h3FF, 8'hFF};
			3: next = '{10'd0, 10'h3FF, 10'd0, 8'd0};
			5: next = '{LOW_THRESHOLD_RST, RISE_THRESHOLD_RST, FALL_THRESHOLD_RST, LAG_STEPS_RST};
			default: begin
				next.low_threshold  = 10'($urandom_range(50, 600));
				next.rise_threshold = 10'($urandom_range(300, 900));
				next.fall_threshold = 10'($urandom_range(100, next.rise_threshold));
				next.lag_steps      = 8'($urandom());
			end
		endcase
		write_reg(REG_LOW, 32'(next.low_threshold), 10);
		write_reg(REG_RISE, 32'(next.rise_threshold), 10);
		write_reg(REG_FALL, 32'(next.fall_threshold), 10);
		write_reg(REG_LAG, 32'(next.lag_steps), 8);
		cur_cfg = next;
	endtask

	task automatic run_directed();
		int k;
		send_word(CMD_START, 10'h3FF, -16'sd1);
		send_word(CMD_SAMPLE, 10'h3FF, 16'sd0);
		send_word(CMD_SAMPLE, 10'd0, 16'sh7FFF);
		// start edge wraps positive after the lag, end lands negative: wrapped center
		for (k = 0; k < 5; k++)
			send_word(CMD_SAMPLE, 10'h3FF, 16'(-32768 + k));
		for (k = 0; k < 7; k++)
			send_word(CMD_SAMPLE, 10'd0, 16'(-32760 + k));
		send_word(CMD_SAMPLE, 10'd512, 16'sd5);
		send_word(CMD_START, 10'd0, 16'sd0);
		send_word(CMD_SAMPLE, 10'd275, 16'sd1);
		send_word(CMD_SAMPLE, 10'd274, 16'sd2);
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 8);
		repeat (n)
			send_word(($urandom_range(7) == 0) ? CMD_START : CMD_SAMPLE,
				10'($urandom()), 16'($urandom()));
	endtask

	// One homing pass: start, arm, climb into the band, drop out, a few trailing samples
	task automatic run_band_sweep();
		logic signed [15:0] pos;
		int step;
		int hi_floor;
		int lo_ceil;
		int arm_ceil;
		pos      = 16'($urandom());
		step     = $urandom_range(1, 40);
		hi_floor = (cur_cfg.rise_threshold == 10'h3FF) ? 1023 : cur_cfg.rise_threshold + 1;
		lo_ceil  = (cur_cfg.fall_threshold == 10'd0) ? 0 : cur_cfg.fall_threshold - 1;
		arm_ceil = (cur_cfg.low_threshold == 10'd0) ? 0 : cur_cfg.low_threshold - 1;
		if ($urandom_range(3) == 0)
			step = -step;
		send_word(CMD_START, 10'($urandom()), 16'($urandom()));
		send_word(CMD_SAMPLE, 10'($urandom_range(0, arm_ceil)), pos);
		repeat ($urandom_range(4, 16)) begin
			pos = 16'(pos + step);
			send_word(CMD_SAMPLE, 10'($urandom_range(hi_floor, 1023)), pos);
		end
		repeat ($urandom_range(0, 16)) begin
			pos = 16'(pos + step);
			send_word(CMD_SAMPLE, 10'($urandom_range(0, lo_ceil)), pos);
		end
		repeat ($urandom_range(0, 4)) begin
			pos = 16'(pos + step);
			send_word(CMD_SAMPLE, 10'($urandom()), pos);
		end
	endtask

	initial begin
		int chunk;
		int chunk_goal;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		cmd      = CMD_SAMPLE;
		sample   = '0;
		position = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		cur_cfg  = '{LOW_THRESHOLD_RST, RISE_THRESHOLD_RST, FALL_THRESHOLD_RST, LAG_STEPS_RST};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		for (chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
			in_valid <= 1'b0;
			drain_results();
			apply_setting(chunk);
			case (chunk / 2)
				0: begin
					tx_idle_pct = 38;
					rx_idle_pct = 59;
				end
				1: begin
					tx_idle_pct = 59;
					rx_idle_pct = 38;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			// hold the output side so the pipeline backs up into the input
			if (chunk == 4)
				backlog_req++;
			chunk_goal = sent_words + CHUNK_WORDS;
			while (sent_words < chunk_goal) begin
				if ($urandom_range(4) == 0)
					send_noise();
				else
					run_band_sweep();
			end
		end
		in_valid <= 1'b0;
		drain_results();
		$display("Sent %0d words under %0d register settings; %0d result words checked.",
			sent_words, NUM_CHUNKS + 1, words_checked);
		$display("Band centers located: %0d, including wrapped bands and one long output backlog.",
			bands_found);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
